>>> design/scrfm_pkg.sv
`default_nettype none
package scrfm_pkg;

    localparam int unsigned CNT_W      = 64;
    localparam int unsigned HALF_W     = CNT_W / 2;
    localparam int unsigned DIV_CNT_W  = $clog2(CNT_W);
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned QDEPTH     = 2;
    localparam int unsigned QPTR_W     = $clog2(QDEPTH);

    localparam logic [15:0] NEEDED_ENABLES    = 16'h0003;
    localparam logic [1:0]  LOCK_AGREEMENTS   = 2'd2;
    localparam logic [31:0] TOLERANCE_RESET   = 32'd10_000_000;
    localparam logic [7:0]  MAX_SAMPLES_RESET = 8'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FEATURE     = 3'd0,
        CFG_ENABLES     = 3'd1,
        CFG_REF_HZ      = 3'd2,
        CFG_TOL_HZ      = 3'd3,
        CFG_MAX_SAMPLES = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_MEASURING   = 2'd0,
        ST_LOCKED      = 2'd1,
        ST_FAILED      = 2'd2,
        ST_UNAVAILABLE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        JOB_RUN     = 2'd0,
        JOB_SKIP    = 2'd1,
        JOB_UNAVAIL = 2'd2
    } t_job_kind;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL_LO,
        BK_MUL_HI,
        BK_SUM,
        BK_DIV,
        BK_DIFF,
        BK_UPDATE
    } t_back_state;

    typedef struct packed {
        logic [CNT_W-1:0] cycles_start;
        logic [CNT_W-1:0] ref_start;
        logic [CNT_W-1:0] cycles_end;
        logic [CNT_W-1:0] ref_end;
    } t_in_item;

    typedef struct packed {
        t_status          status;
        logic [CNT_W-1:0] freq_hz;
    } t_out_item;

    typedef struct packed {
        logic        feature_present;
        logic [15:0] counter_enable_bits;
        logic [31:0] reference_hz;
        logic [31:0] tolerance_hz;
        logic [7:0]  max_samples;
    } t_cfg;

    typedef struct packed {
        t_job_kind        kind;
        logic [CNT_W-1:0] dcyc;
        logic [CNT_W-1:0] dref;
    } t_job;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [CNT_W-1:0] quotient;
    } t_div_rsp;

endpackage
`default_nettype wire

>>> design/scrfm_front.sv
`default_nettype none
module scrfm_front (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [scrfm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [scrfm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                                i_push,
    output logic                                     o_full,
    input  wire scrfm_pkg::t_in_item                 i_item,
    output scrfm_pkg::t_cfg                          o_cfg,
    output logic                                     o_job_valid,
    output scrfm_pkg::t_job                          o_job,
    input  wire logic                                i_job_ready
);

    scrfm_pkg::t_cfg  r_cfg;
    scrfm_pkg::t_job  r_job;
    scrfm_pkg::t_job  n_job;
    logic             r_job_valid;
    logic             w_accept;
    logic             w_unavail;

    assign o_full      = r_job_valid && !i_job_ready;
    assign w_accept    = i_push && !o_full;
    assign o_cfg       = r_cfg;
    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.feature_present     <= 1'b0;
            r_cfg.counter_enable_bits <= '0;
            r_cfg.reference_hz        <= '0;
            r_cfg.tolerance_hz        <= scrfm_pkg::TOLERANCE_RESET;
            r_cfg.max_samples         <= scrfm_pkg::MAX_SAMPLES_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                scrfm_pkg::CFG_FEATURE:     r_cfg.feature_present     <= i_cfg_data[0];
                scrfm_pkg::CFG_ENABLES:     r_cfg.counter_enable_bits <= i_cfg_data[15:0];
                scrfm_pkg::CFG_REF_HZ:      r_cfg.reference_hz        <= i_cfg_data;
                scrfm_pkg::CFG_TOL_HZ:      r_cfg.tolerance_hz        <= i_cfg_data;
                scrfm_pkg::CFG_MAX_SAMPLES: r_cfg.max_samples         <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_unavail = !r_cfg.feature_present || (r_cfg.reference_hz == '0) ||
                    ((r_cfg.counter_enable_bits & scrfm_pkg::NEEDED_ENABLES) !=
                     scrfm_pkg::NEEDED_ENABLES);
        n_job.dcyc = i_item.cycles_end - i_item.cycles_start;
        n_job.dref = i_item.ref_end - i_item.ref_start;
        if (w_unavail) begin
            n_job.kind = scrfm_pkg::JOB_UNAVAIL;
        end else if ((n_job.dcyc == '0) || (n_job.dref == '0)) begin
            n_job.kind = scrfm_pkg::JOB_SKIP;
        end else begin
            n_job.kind = scrfm_pkg::JOB_RUN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
        end else if (w_accept) begin
            r_job_valid <= 1'b1;
        end else if (i_job_ready) begin
            r_job_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_job <= n_job;
        end
    end

endmodule
`default_nettype wire

>>> design/scrfm_queue.sv
`default_nettype none
module scrfm_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire scrfm_pkg::t_job   i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output scrfm_pkg::t_job        o_data
);

    scrfm_pkg::t_job               r_mem [scrfm_pkg::QDEPTH];
    logic [scrfm_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [scrfm_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [scrfm_pkg::QPTR_W:0]    r_count;
    logic                          w_wr;
    logic                          w_rd;

    assign o_full  = (r_count == (scrfm_pkg::QPTR_W + 1)'(scrfm_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

>>> design/scrfm_div.sv
`default_nettype none
module scrfm_div (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire scrfm_pkg::t_div_req  i_req,
    output scrfm_pkg::t_div_rsp       o_rsp
);

    logic                              r_busy;
    logic                              r_done;
    logic [scrfm_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [scrfm_pkg::CNT_W-1:0]       r_rem;
    logic [scrfm_pkg::CNT_W-1:0]       r_quo;
    logic [scrfm_pkg::CNT_W-1:0]       r_div;
    logic [scrfm_pkg::CNT_W:0]         w_shift;
    logic [scrfm_pkg::CNT_W:0]         w_diff;
    logic                              w_ge;
    logic                              w_last;

    assign w_shift = {r_rem, r_quo[scrfm_pkg::CNT_W-1]};
    assign w_diff  = w_shift - {1'b0, r_div};
    assign w_ge    = !w_diff[scrfm_pkg::CNT_W];
    assign w_last  = (r_cnt == scrfm_pkg::DIV_CNT_W'(scrfm_pkg::CNT_W - 1));

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[scrfm_pkg::CNT_W-1:0] : w_shift[scrfm_pkg::CNT_W-1:0];
            r_quo <= {r_quo[scrfm_pkg::CNT_W-2:0], w_ge};
        end
    end

endmodule
`default_nettype wire

>>> design/scrfm_back.sv
`default_nettype none
module scrfm_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire scrfm_pkg::t_cfg      i_cfg,
    input  wire logic                 i_job_empty,
    input  wire scrfm_pkg::t_job      i_job,
    output logic                      o_job_pop,
    output scrfm_pkg::t_div_req       o_div_req,
    input  wire scrfm_pkg::t_div_rsp  i_div_rsp,
    output logic                      o_empty,
    input  wire logic                 i_pop,
    output scrfm_pkg::t_out_item      o_result
);

    scrfm_pkg::t_back_state        r_state;
    scrfm_pkg::t_back_state        n_state;
    scrfm_pkg::t_job               r_job;
    logic [scrfm_pkg::CNT_W-1:0]   r_prod_lo;
    logic [scrfm_pkg::HALF_W-1:0]  r_prod_hi;
    logic [scrfm_pkg::CNT_W-1:0]   r_quot;
    logic [scrfm_pkg::CNT_W-1:0]   r_diff;
    logic [scrfm_pkg::CNT_W-1:0]   r_last;
    logic [scrfm_pkg::CNT_W-1:0]   n_last;
    logic [1:0]                    r_agree;
    logic [1:0]                    n_agree;
    logic [7:0]                    r_windows;
    logic [7:0]                    n_windows;
    logic                          r_res_valid;
    scrfm_pkg::t_out_item          r_result;
    scrfm_pkg::t_out_item          n_result;
    logic                          w_res_load;
    logic                          w_reading;
    logic                          w_locked;
    logic [scrfm_pkg::HALF_W-1:0]  w_mul_a;
    logic [scrfm_pkg::CNT_W-1:0]   w_mul;

    assign w_mul_a = (r_state == scrfm_pkg::BK_MUL_HI) ?
                     r_job.dcyc[scrfm_pkg::CNT_W-1:scrfm_pkg::HALF_W] :
                     r_job.dcyc[scrfm_pkg::HALF_W-1:0];
    assign w_mul   = scrfm_pkg::CNT_W'(w_mul_a) * scrfm_pkg::CNT_W'(i_cfg.reference_hz);

    assign o_div_req.dividend = r_prod_lo + {r_prod_hi, {scrfm_pkg::HALF_W{1'b0}}};
    assign o_div_req.divisor  = r_job.dref;
    assign o_empty            = !r_res_valid;
    assign o_result           = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scrfm_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_job_pop       = 1'b0;
        o_div_req.start = 1'b0;
        w_res_load      = 1'b0;
        unique case (r_state)
            scrfm_pkg::BK_IDLE: begin
                if (!i_job_empty) begin
                    o_job_pop = 1'b1;
                    n_state   = (i_job.kind == scrfm_pkg::JOB_RUN) ?
                                scrfm_pkg::BK_MUL_LO : scrfm_pkg::BK_UPDATE;
                end
            end
            scrfm_pkg::BK_MUL_LO: n_state = scrfm_pkg::BK_MUL_HI;
            scrfm_pkg::BK_MUL_HI: n_state = scrfm_pkg::BK_SUM;
            scrfm_pkg::BK_SUM: begin
                o_div_req.start = 1'b1;
                n_state         = scrfm_pkg::BK_DIV;
            end
            scrfm_pkg::BK_DIV: begin
                if (i_div_rsp.done) begin
                    n_state = scrfm_pkg::BK_DIFF;
                end
            end
            scrfm_pkg::BK_DIFF: n_state = scrfm_pkg::BK_UPDATE;
            scrfm_pkg::BK_UPDATE: begin
                if (!r_res_valid || i_pop) begin
                    w_res_load = 1'b1;
                    n_state    = scrfm_pkg::BK_IDLE;
                end
            end
            default: n_state = scrfm_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job  <= i_job;
            r_quot <= '0;
        end
        if (r_state == scrfm_pkg::BK_MUL_LO) begin
            r_prod_lo <= w_mul;
        end
        if (r_state == scrfm_pkg::BK_MUL_HI) begin
            r_prod_hi <= w_mul[scrfm_pkg::HALF_W-1:0];
        end
        if ((r_state == scrfm_pkg::BK_DIV) && i_div_rsp.done) begin
            r_quot <= i_div_rsp.quotient;
        end
        if (r_state == scrfm_pkg::BK_DIFF) begin
            r_diff <= (r_quot > r_last) ? (r_quot - r_last) : (r_last - r_quot);
        end
    end

    always_comb begin
        n_windows = r_windows + 8'd1;
        n_agree   = r_agree;
        n_last    = r_last;
        w_locked  = 1'b0;
        w_reading = (r_job.kind == scrfm_pkg::JOB_RUN) && (r_quot != '0);
        n_result.status  = scrfm_pkg::ST_MEASURING;
        n_result.freq_hz = '0;
        if (w_reading) begin
            if (r_last != '0) begin
                if (r_diff <= scrfm_pkg::CNT_W'(i_cfg.tolerance_hz)) begin
                    n_agree  = r_agree + 2'd1;
                    w_locked = (n_agree >= scrfm_pkg::LOCK_AGREEMENTS);
                end else begin
                    n_agree = '0;
                end
            end
            n_last = r_quot;
        end
        if (r_job.kind == scrfm_pkg::JOB_UNAVAIL) begin
            n_result.status = scrfm_pkg::ST_UNAVAILABLE;
        end else if (w_locked) begin
            n_result.status  = scrfm_pkg::ST_LOCKED;
            n_result.freq_hz = r_quot;
        end else if (n_windows >= i_cfg.max_samples) begin
            n_result.status = scrfm_pkg::ST_FAILED;
        end
        if (n_result.status != scrfm_pkg::ST_MEASURING) begin
            n_windows = '0;
            n_agree   = '0;
            n_last    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last      <= '0;
            r_agree     <= '0;
            r_windows   <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (w_res_load) begin
                r_last      <= n_last;
                r_agree     <= n_agree;
                r_windows   <= n_windows;
                r_res_valid <= 1'b1;
            end else if (i_pop) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_result <= n_result;
        end
    end

endmodule
`default_nettype wire

>>> design/stable_counter_ratio_freq_meter.sv
// A measured window runs through two 32x32 multiply steps, a sum and a 64-step restoring
// divider before its result; skipped or unavailable windows go straight to the update step.
// The back end takes one window at a time, so the single divider in the back end sets the pace;
// a staging beat and a two-entry queue let pushes run ahead of the divider.
// Reset (synchronous, active low) clears all measurement state, queues and the result
// slot, and loads register defaults: tolerance 10000000 Hz, sample limit 10.
`default_nettype none
module stable_counter_ratio_freq_meter (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [scrfm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [scrfm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                              push,
    output logic                                   full,
    input  wire scrfm_pkg::t_in_item               i_item,
    output logic                                   empty,
    input  wire logic                              pop,
    output scrfm_pkg::t_out_item                   o_result
);

    scrfm_pkg::t_cfg      w_cfg;
    scrfm_pkg::t_job      w_stage_job;
    scrfm_pkg::t_job      w_q_job;
    scrfm_pkg::t_div_req  w_div_req;
    scrfm_pkg::t_div_rsp  w_div_rsp;
    logic                 w_q_push;
    logic                 w_q_full;
    logic                 w_q_empty;
    logic                 w_q_pop;

    scrfm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .o_cfg       (w_cfg),
        .o_job_valid (w_q_push),
        .o_job       (w_stage_job),
        .i_job_ready (!w_q_full)
    );

    scrfm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_stage_job),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_data  (w_q_job)
    );

    scrfm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    scrfm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_job_empty (w_q_empty),
        .i_job       (w_q_job),
        .o_job_pop   (w_q_pop),
        .o_div_req   (w_div_req),
        .i_div_rsp   (w_div_rsp),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

    a_freq_only_when_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_result.status != scrfm_pkg::ST_LOCKED)) |-> (o_result.freq_hz == '0))
        else $error("nonzero frequency on a result that is not locked");

    a_stage_waits_on_full_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_push && w_q_full) |=> w_q_push)
        else $error("staged window dropped while queue full");

    a_div_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> !w_div_rsp.busy)
        else $error("divider restarted while busy");

    a_div_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> ($past(w_div_rsp.busy) && !w_div_rsp.busy))
        else $error("divider done without a finished run");

endmodule
`default_nettype wire
